// File: sv/yrgb_pkg.sv
// ============================================================================
// yrgb_pkg
// Shared widths and conversion constants for the YUV/RGB to RGB555 converter.
// ============================================================================
package yrgb_pkg;

  localparam int unsigned COMP_W  = 8;   // one input byte
  localparam int unsigned CH5_W   = 5;   // one packed channel
  localparam int unsigned PIX_W   = 3 * CH5_W;
  localparam int unsigned OFS_W   = COMP_W + 1;  // byte minus offset, signed
  localparam int unsigned PROD_W  = 19;  // coefficient times offset value
  localparam int unsigned SUM_W   = PROD_W + 1;

  // source_format codes
  localparam logic FMT_RGB = 1'b0;
  localparam logic FMT_YUV = 1'b1;
  localparam logic FMT_RESET = FMT_YUV;

  // BT.601 limited range, 8.8 fixed point
  localparam logic signed [OFS_W-1:0]  Y_OFFSET   = 9'sd16;
  localparam logic signed [OFS_W-1:0]  C_OFFSET   = 9'sd128;
  localparam logic signed [PROD_W-1:0] K_LUMA     = 19'sd298;
  localparam logic signed [PROD_W-1:0] K_RV       = 19'sd409;
  localparam logic signed [PROD_W-1:0] K_GU       = 19'sd100;
  localparam logic signed [PROD_W-1:0] K_GV       = 19'sd208;
  localparam logic signed [PROD_W-1:0] K_BU       = 19'sd516;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 19'sd128;

  // Top five bits of a byte packed as red, green, blue.
  function automatic logic [PIX_W-1:0] pack_bytes(
    logic [COMP_W-1:0] red, logic [COMP_W-1:0] green, logic [COMP_W-1:0] blue);
    return {red[COMP_W-1 -: CH5_W], green[COMP_W-1 -: CH5_W],
            blue[COMP_W-1 -: CH5_W]};
  endfunction

endpackage

// File: sv/yrgb_if.sv
// ============================================================================
// yrgb channel interfaces
// Valid/ready channels for input pixels, packed output pixels and the
// source format register write.
// ============================================================================
interface yrgb_pix_in_if;
  logic                         valid;
  logic                         ready;
  logic [yrgb_pkg::COMP_W-1:0]  first_component;
  logic [yrgb_pkg::COMP_W-1:0]  second_component;
  logic [yrgb_pkg::COMP_W-1:0]  third_component;

  modport source (output valid, first_component, second_component, third_component,
                  input ready);
  modport sink   (input valid, first_component, second_component, third_component,
                  output ready);
endinterface

interface yrgb_pix_out_if;
  logic                        valid;
  logic                        ready;
  logic [yrgb_pkg::PIX_W-1:0]  pixel_rgb555;

  modport source (output valid, pixel_rgb555, input ready);
  modport sink   (input valid, pixel_rgb555, output ready);
endinterface

interface yrgb_cfg_if;
  logic valid;
  logic ready;
  logic source_format;

  modport source (output valid, source_format, input ready);
  modport sink   (input valid, source_format, output ready);
endinterface

// File: sv/yuv_rgb_to_rgb555_converter_unit.sv
// ============================================================================
// yuv_rgb_to_rgb555_converter_unit
// Pixel converter: Y,U,V (BT.601 limited range) or B,G,R bytes to RGB555.
// ============================================================================
// One pixel per transfer on pix_i, one RGB555 word per transfer on pix_o, in
// order. A pixel can be taken every clock while pix_o does not stall. Four
// register stages (offset, multiply, sum, clamp/pack); the input transfer
// edge loads the first, and the word then passes the multiply and sum stages
// into the output register, where pix_o.valid rises and pix_o can take it.
// The four stages advance together: while the output register holds a word
// that pix_o does not take, the whole pipe and pix_i.ready hold, otherwise
// everything moves one stage per cycle. source_format resets to YUV; it is
// captured with each pixel at entry, and cfg_i is always ready. In YUV mode
// each channel is (298(Y-16) + k*(C-128) + 128) >> 8 clamped to 0..255; the
// top five bits of each channel are packed red 14:10, green 9:5, blue 4:0.
// ============================================================================
module yuv_rgb_to_rgb555_converter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  yrgb_cfg_if.sink           cfg_i,
  yrgb_pix_in_if.sink        pix_i,
  yrgb_pix_out_if.source     pix_o
);

  localparam int unsigned COMP_W = yrgb_pkg::COMP_W;
  localparam int unsigned CH5_W  = yrgb_pkg::CH5_W;
  localparam int unsigned PIX_W  = yrgb_pkg::PIX_W;
  localparam int unsigned OFS_W  = yrgb_pkg::OFS_W;
  localparam int unsigned PROD_W = yrgb_pkg::PROD_W;
  localparam int unsigned SUM_W  = yrgb_pkg::SUM_W;

  // Channel sum to its top five bits after >>8 and clamp to 0..255.
  function automatic logic [CH5_W-1:0] clamp_top5(logic signed [SUM_W-1:0] s);
    logic [CH5_W-1:0] r;
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (|s[SUM_W-2:COMP_W+8]) begin
      r = '1;
    end else begin
      r = s[COMP_W+7 -: CH5_W];
    end
    return r;
  endfunction

  // --- source format register ----------------------------------------------
  logic fmt_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= yrgb_pkg::FMT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      fmt_q <= cfg_i.source_format;
    end
  end

  // --- pipeline enable --------------------------------------------------------
  // Single stall point: the output register.
  logic out_vld_q;
  logic adv;

  assign adv         = !out_vld_q || pix_o.ready;
  assign pix_i.ready = adv;

  // --- stage 1: remove offsets ------------------------------------------------
  logic                    s1_vld_q;
  logic                    s1_fmt_q;
  logic [PIX_W-1:0]        s1_rgb_q;
  logic signed [OFS_W-1:0] s1_cy_q, s1_du_q, s1_ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_fmt_q <= fmt_q;
      // RGB mode: first is blue, third is red
      s1_rgb_q <= yrgb_pkg::pack_bytes(pix_i.third_component, pix_i.second_component,
                                       pix_i.first_component);
      s1_cy_q  <= $signed({1'b0, pix_i.first_component})  - yrgb_pkg::Y_OFFSET;
      s1_du_q  <= $signed({1'b0, pix_i.second_component}) - yrgb_pkg::C_OFFSET;
      s1_ev_q  <= $signed({1'b0, pix_i.third_component})  - yrgb_pkg::C_OFFSET;
    end
  end

  // --- stage 2: coefficient products ------------------------------------------
  logic                     s2_vld_q;
  logic                     s2_fmt_q;
  logic [PIX_W-1:0]         s2_rgb_q;
  logic signed [PROD_W-1:0] s2_luma_q, s2_rv_q, s2_gu_q, s2_gv_q, s2_bu_q;
  logic signed [PROD_W-1:0] cy_x, du_x, ev_x;

  assign cy_x = PROD_W'(s1_cy_q);
  assign du_x = PROD_W'(s1_du_q);
  assign ev_x = PROD_W'(s1_ev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_fmt_q  <= s1_fmt_q;
      s2_rgb_q  <= s1_rgb_q;
      s2_luma_q <= yrgb_pkg::K_LUMA * cy_x + yrgb_pkg::ROUND_HALF;  // rounding folded in
      s2_rv_q   <= yrgb_pkg::K_RV * ev_x;
      s2_gu_q   <= yrgb_pkg::K_GU * du_x;
      s2_gv_q   <= yrgb_pkg::K_GV * ev_x;
      s2_bu_q   <= yrgb_pkg::K_BU * du_x;
    end
  end

  // --- stage 3: channel sums --------------------------------------------------
  logic                    s3_vld_q;
  logic                    s3_fmt_q;
  logic [PIX_W-1:0]        s3_rgb_q;
  logic signed [SUM_W-1:0] s3_r_q, s3_g_q, s3_b_q;
  logic signed [SUM_W-1:0] luma_x;

  assign luma_x = SUM_W'(s2_luma_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_fmt_q <= s2_fmt_q;
      s3_rgb_q <= s2_rgb_q;
      s3_r_q   <= luma_x + SUM_W'(s2_rv_q);
      s3_g_q   <= luma_x - SUM_W'(s2_gu_q) - SUM_W'(s2_gv_q);
      s3_b_q   <= luma_x + SUM_W'(s2_bu_q);
    end
  end

  // --- stage 4: clamp, pack, output register ----------------------------------
  logic [PIX_W-1:0] out_pix_q;
  logic [PIX_W-1:0] out_pix_d;

  always_comb begin
    unique case (s3_fmt_q)
      yrgb_pkg::FMT_YUV: out_pix_d = {clamp_top5(s3_r_q), clamp_top5(s3_g_q),
                                      clamp_top5(s3_b_q)};
      default:           out_pix_d = s3_rgb_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q <= out_pix_d;
    end
  end

  assign pix_o.valid        = out_vld_q;
  assign pix_o.pixel_rgb555 = out_pix_q;

endmodule

// File: sv/yrgb_checker.sv
// ============================================================================
// yrgb_checker
// Port-level checks for the RGB555 converter, bound to the top level.
// ============================================================================
module yrgb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_i,
  input logic                         cfg_format_i,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [yrgb_pkg::COMP_W-1:0]  in_first_i,
  input logic [yrgb_pkg::COMP_W-1:0]  in_second_i,
  input logic [yrgb_pkg::COMP_W-1:0]  in_third_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [yrgb_pkg::PIX_W-1:0]   out_pixel_i
);

  logic       fmt_q;
  logic [2:0] flow_cnt_q;
  logic       in_xfer;
  logic       flow4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= yrgb_pkg::FMT_RESET;
    end else if (cfg_valid_i && cfg_ready_i) begin
      fmt_q <= cfg_format_i;
    end
  end

  // Consecutive out-of-reset edges with output ready high, saturating at four.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_cnt_q <= '0;
    end else if (!out_ready_i) begin
      flow_cnt_q <= '0;
    end else if (flow_cnt_q != 3'd4) begin
      flow_cnt_q <= flow_cnt_q + 3'd1;
    end
  end

  assign in_xfer = in_valid_i && in_ready_i;

  // Counter saturated: output ready was high, so the pipe moved, at every edge it counts.
  assign flow4 = (flow_cnt_q == 3'd4);

  // Output holds while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pixel_i))
    else $error("output word changed while stalled");

  // Input side stalls exactly when the output word is stuck.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == !(out_valid_i && !out_ready_i))
    else $error("input ready does not follow output stall");

  // Without backpressure every accepted pixel appears after the offset, multiply, sum and output registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flow4 |-> out_valid_i == $past(in_xfer, 4))
    else $error("pixel lost or invented in free-flowing pipe");

  // RGB mode keeps the top five bits of each byte.
  a_rgb_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flow4 && $past(in_xfer, 4) && ($past(fmt_q, 4) == yrgb_pkg::FMT_RGB) |->
      out_pixel_i == yrgb_pkg::pack_bytes($past(in_third_i, 4), $past(in_second_i, 4),
                                          $past(in_first_i, 4)))
    else $error("RGB mode packing mismatch");

endmodule

bind yuv_rgb_to_rgb555_converter_unit yrgb_checker u_yrgb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready),
  .cfg_format_i (cfg_i.source_format),
  .in_valid_i   (pix_i.valid),
  .in_ready_i   (pix_i.ready),
  .in_first_i   (pix_i.first_component),
  .in_second_i  (pix_i.second_component),
  .in_third_i   (pix_i.third_component),
  .out_valid_i  (pix_o.valid),
  .out_ready_i  (pix_o.ready),
  .out_pixel_i  (pix_o.pixel_rgb555)
);
